// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hill3_pkg.sv
package hill3_pkg;

  localparam int MODULUS = 26;
  localparam int MAT_N   = 9;
  localparam logic [10:0] MOD_SQ = 11'd676;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_ROW0 = 2'd0;
  localparam logic [1:0] REG_KEY_ROW1 = 2'd1;
  localparam logic [1:0] REG_KEY_ROW2 = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  localparam logic [1:0] LAST_COL = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       key_load;
    logic       inv_mode;
    logic       prod_en;
    logic [3:0] prod_idx;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic       det_sum;
    logic       det_done;
    logic       copy_key;
    logic       step;
    logic       col_sum;
    logic       out_load;
    logic       err_load;
    logic [1:0] col;
  } hill3_cmd_t;

  typedef struct packed {
    logic good;
    logic mode;
    logic emit3;
    logic err;
    logic last;
    logic out_free;
  } hill3_status_t;

  // x mod 26 for x < 2048, by conditional subtraction of 26 * 2^s
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [10:0] r;
    r = x;
    for (int s = 6; s >= 0; s--) begin
      if (r >= (11'(MODULUS) << s)) r = r - (11'(MODULUS) << s);
    end
    return r[4:0];
  endfunction

  function automatic logic [4:0] reduce5(input logic [4:0] x);
    return (x >= 5'(MODULUS)) ? 5'(x - 5'(MODULUS)) : x;
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic logic [4:0] inv26(input logic [4:0] d);
    logic [4:0] r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // row-major index n = 3i+j mapped to 3j+i
  function automatic logic [3:0] transpose_idx(input logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'd1:    r = 4'd3;
      4'd2:    r = 4'd6;
      4'd3:    r = 4'd1;
      4'd5:    r = 4'd7;
      4'd6:    r = 4'd2;
      4'd7:    r = 4'd5;
      default: r = n;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/hill3_if.sv
interface hill3_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter_code;
  logic       message_end;

  modport source (output valid, output letter_code, output message_end, input ready);
  modport sink   (input valid, input letter_code, input message_end, output ready);
endinterface

interface hill3_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_letter;
  logic       key_error;
  logic       run_last;

  modport source (output valid, output out_letter, output key_error, output run_last,
                  input ready);
  modport sink   (input valid, input out_letter, input key_error, input run_last,
                  output ready);
endinterface

// File: hdl/hill3_ctrl.sv
module hill3_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  hill3_pkg::hill3_status_t status_i,
  output hill3_pkg::hill3_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_KEY  = 11'b000_0000_0010,
    S_COF  = 11'b000_0000_0100,
    S_DETP = 11'b000_0000_1000,
    S_DETM = 11'b000_0001_0000,
    S_PICK = 11'b000_0010_0000,
    S_INV  = 11'b000_0100_0000,
    S_STEP = 11'b000_1000_0000,
    S_SUM  = 11'b001_0000_0000,
    S_OUT  = 11'b010_0000_0000,
    S_ERR  = 11'b100_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] col_q, col_d;
  logic       mtx_ready_q, mtx_ready_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    mtx_ready_d = mtx_ready_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.col   = col_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = mtx_ready_q ? S_STEP : S_KEY;
        end
      end
      S_KEY: begin
        cmd_o.key_load = 1'b1;
        cnt_d   = '0;
        state_d = S_COF;
      end
      S_COF, S_INV: begin
        // product for entry cnt; entry cnt-1 is reduced from the product registered in the previous cycle
        cmd_o.inv_mode = (state_q == S_INV);
        cmd_o.prod_en  = (cnt_q < 4'(hill3_pkg::MAT_N));
        cmd_o.prod_idx = cnt_q;
        cmd_o.wr_en    = (cnt_q != 4'd0);
        cmd_o.wr_idx   = 4'(cnt_q - 4'd1);
        cnt_d = 4'(cnt_q + 4'd1);
        if (cnt_q == 4'(hill3_pkg::MAT_N)) begin
          state_d = (state_q == S_INV) ? S_STEP : S_DETP;
        end
      end
      S_DETP: begin
        cmd_o.det_sum = 1'b1;
        state_d = S_DETM;
      end
      S_DETM: begin
        cmd_o.det_done = 1'b1;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (status_i.good && status_i.mode) begin
          cnt_d   = '0;
          state_d = S_INV;
        end else begin
          cmd_o.copy_key = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step  = 1'b1;
        mtx_ready_d = !status_i.last;
        col_d       = '0;
        priority if (status_i.emit3) state_d = S_SUM;
        else if (status_i.err)       state_d = S_ERR;
        else                         state_d = S_IDLE;
      end
      S_SUM: begin
        cmd_o.col_sum = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (col_q == hill3_pkg::LAST_COL) begin
            state_d = S_IDLE;
          end else begin
            col_d   = 2'(col_q + 2'd1);
            state_d = S_SUM;
          end
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.err_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      col_q       <= '0;
      mtx_ready_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      mtx_ready_q <= mtx_ready_d;
    end
  end

endmodule

// File: hdl/hill3_dp.sv
module hill3_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [14:0]             cfg_data_i,
  input  logic [4:0]              in_letter_i,
  input  logic                    in_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4:0]              out_letter_o,
  output logic                    out_key_error_o,
  output logic                    out_run_last_o,
  input  hill3_pkg::hill3_cmd_t    cmd_i,
  output hill3_pkg::hill3_status_t status_o
);

  logic [14:0] key_row_q [3];
  logic        mode_q;

  logic [4:0]  letter_q;
  logic        end_q;

  logic [4:0]  k_q   [9];
  logic [4:0]  cof_q [9];
  logic [4:0]  act_q [9];
  logic [9:0]  pa_q, pb_q;
  logic [9:0]  pa_d, pb_d;
  logic [10:0] det_sum_q;
  logic [4:0]  dinv_q, dinv_d;
  logic        good_q;
  logic [4:0]  red_val;

  logic [1:0]  bp_q, bp_d;
  logic [1:0]  hc_q, hc_d;
  logic [4:0]  buf_q  [2];
  logic [4:0]  head_q [2];
  logic [4:0]  buf_d  [2];
  logic [4:0]  head_d [2];
  logic [4:0]  v_q [3];
  logic [4:0]  v_d [3];
  logic        last_q;
  logic        long_msg;

  logic [10:0] sum_q, sum_d;
  logic [4:0]  m0, m1, m2;

  logic        out_valid_q;
  logic [4:0]  out_letter_q;
  logic        key_error_q;
  logic        run_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_row_q[0] <= '0;
      key_row_q[1] <= '0;
      key_row_q[2] <= '0;
      mode_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hill3_pkg::REG_KEY_ROW0: key_row_q[0] <= cfg_data_i;
        hill3_pkg::REG_KEY_ROW1: key_row_q[1] <= cfg_data_i;
        hill3_pkg::REG_KEY_ROW2: key_row_q[2] <= cfg_data_i;
        hill3_pkg::REG_MODE:     mode_q       <= cfg_data_i[0];
      endcase
    end
  end

  // operand products: cofactor pair, or cofactor times inverse determinant
  always_comb begin
    pa_d = '0;
    pb_d = '0;
    if (cmd_i.inv_mode) begin
      pa_d = 10'(cof_q[0]) * 10'(dinv_q);
    end else begin
      unique case (cmd_i.prod_idx)
        4'd0: begin pa_d = 10'(k_q[4]) * 10'(k_q[8]); pb_d = 10'(k_q[5]) * 10'(k_q[7]); end
        4'd1: begin pa_d = 10'(k_q[5]) * 10'(k_q[6]); pb_d = 10'(k_q[3]) * 10'(k_q[8]); end
        4'd2: begin pa_d = 10'(k_q[3]) * 10'(k_q[7]); pb_d = 10'(k_q[4]) * 10'(k_q[6]); end
        4'd3: begin pa_d = 10'(k_q[7]) * 10'(k_q[2]); pb_d = 10'(k_q[8]) * 10'(k_q[1]); end
        4'd4: begin pa_d = 10'(k_q[8]) * 10'(k_q[0]); pb_d = 10'(k_q[6]) * 10'(k_q[2]); end
        4'd5: begin pa_d = 10'(k_q[6]) * 10'(k_q[1]); pb_d = 10'(k_q[7]) * 10'(k_q[0]); end
        4'd6: begin pa_d = 10'(k_q[1]) * 10'(k_q[5]); pb_d = 10'(k_q[2]) * 10'(k_q[4]); end
        4'd7: begin pa_d = 10'(k_q[2]) * 10'(k_q[3]); pb_d = 10'(k_q[0]) * 10'(k_q[5]); end
        default: begin pa_d = 10'(k_q[0]) * 10'(k_q[4]); pb_d = 10'(k_q[1]) * 10'(k_q[3]); end
      endcase
    end
  end

  assign red_val = hill3_pkg::mod26(11'(pa_q) + hill3_pkg::MOD_SQ - 11'(pb_q));
  assign dinv_d  = hill3_pkg::inv26(hill3_pkg::mod26(det_sum_q));

  // letter step: group gathering and wrap-around padding of a short final group
  assign long_msg = (hc_q >= 2'd2);

  always_comb begin
    head_d[0] = (hc_q == 2'd0) ? letter_q : head_q[0];
    head_d[1] = (hc_q == 2'd1) ? letter_q : head_q[1];
    buf_d[0]  = buf_q[0];
    buf_d[1]  = buf_q[1];
    v_d[0]    = letter_q;
    v_d[1]    = letter_q;
    v_d[2]    = letter_q;
    bp_d      = 2'd0;
    unique case (bp_q)
      2'd0: begin
        if (long_msg) begin
          v_d[1] = head_d[0];
          v_d[2] = head_d[1];
        end
        buf_d[0] = letter_q;
        bp_d     = end_q ? 2'd0 : 2'd1;
      end
      2'd1: begin
        v_d[0]   = buf_q[0];
        v_d[2]   = long_msg ? head_d[0] : buf_q[0];
        buf_d[1] = letter_q;
        bp_d     = end_q ? 2'd0 : 2'd2;
      end
      default: begin
        v_d[0] = buf_q[0];
        v_d[1] = buf_q[1];
        bp_d   = 2'd0;
      end
    endcase
    if (end_q)                hc_d = 2'd0;
    else if (hc_q == 2'd3)    hc_d = 2'd3;
    else                      hc_d = 2'(hc_q + 2'd1);
  end

  // column select for the vector-matrix product
  always_comb begin
    unique case (cmd_i.col)
      2'd0:    begin m0 = act_q[0]; m1 = act_q[3]; m2 = act_q[6]; end
      2'd1:    begin m0 = act_q[1]; m1 = act_q[4]; m2 = act_q[7]; end
      default: begin m0 = act_q[2]; m1 = act_q[5]; m2 = act_q[8]; end
    endcase
    sum_d = 11'(10'(v_q[0]) * 10'(m0)) + 11'(10'(v_q[1]) * 10'(m1))
          + 11'(10'(v_q[2]) * 10'(m2));
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      letter_q <= hill3_pkg::reduce5(in_letter_i);
      end_q    <= in_end_i;
    end
    if (cmd_i.key_load) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          k_q[3*r+c] <= hill3_pkg::reduce5(key_row_q[r][5*c +: 5]);
        end
      end
    end
    if (cmd_i.prod_en) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (!cmd_i.inv_mode && cmd_i.wr_en) begin
      for (int i = 0; i < 8; i++) cof_q[i] <= cof_q[i+1];
      cof_q[8] <= red_val;
    end else if (cmd_i.inv_mode && cmd_i.prod_en) begin
      for (int i = 0; i < 8; i++) cof_q[i] <= cof_q[i+1];
      cof_q[8] <= cof_q[0];
    end
    if (cmd_i.inv_mode && cmd_i.wr_en) begin
      act_q[hill3_pkg::transpose_idx(cmd_i.wr_idx)] <= red_val;
    end else if (cmd_i.copy_key) begin
      act_q <= k_q;
    end
    if (cmd_i.det_sum) begin
      det_sum_q <= 11'(10'(k_q[0]) * 10'(cof_q[0])) + 11'(10'(k_q[1]) * 10'(cof_q[1]))
                 + 11'(10'(k_q[2]) * 10'(cof_q[2]));
    end
    if (cmd_i.det_done) begin
      dinv_q <= dinv_d;
      good_q <= (dinv_d != 5'd0);
    end
    if (cmd_i.step) begin
      v_q    <= v_d;
      last_q <= end_q;
    end
    if (cmd_i.col_sum) sum_q <= sum_d;
    if (cmd_i.out_load) begin
      out_letter_q <= hill3_pkg::mod26(sum_q);
      key_error_q  <= 1'b0;
      run_last_q   <= last_q && (cmd_i.col == hill3_pkg::LAST_COL);
    end else if (cmd_i.err_load) begin
      out_letter_q <= 5'd0;
      key_error_q  <= 1'b1;
      run_last_q   <= 1'b1;
    end
  end

  // message state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q        <= '0;
      hc_q        <= '0;
      buf_q[0]    <= '0;
      buf_q[1]    <= '0;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        bp_q   <= bp_d;
        hc_q   <= hc_d;
        buf_q  <= buf_d;
        head_q <= head_d;
      end
      if (cmd_i.out_load || cmd_i.err_load) out_valid_q <= 1'b1;
      else if (out_ready_i)                 out_valid_q <= 1'b0;
    end
  end

  assign status_o.good     = good_q;
  assign status_o.mode     = mode_q;
  assign status_o.emit3    = good_q && ((bp_q == 2'd2) || end_q);
  assign status_o.err      = end_q && !good_q;
  assign status_o.last     = end_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_letter_o    = out_letter_q;
  assign out_key_error_o = key_error_q;
  assign out_run_last_o  = run_last_q;

endmodule

// File: hdl/hill_cipher_3x3_mod26_core.sv
// 3x3 Hill cipher over letter codes 0..25.
// Input channel in_if: one letter per transaction, message_end marks the final
// letter. Output channel out_if: transformed letters, three per completed group
// of three; a short final group is padded from the first letters of the message.
// A key whose determinant has no inverse mod 26 gives no letters, only a single
// transaction with key_error and run_last set on the final letter.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write key rows 0..2 and the mode
// (0 encrypt, 1 decrypt with inverse key); the key is taken at a message's
// first letter.
// Sequence: while a group fills, each accepted letter passes the step state and
// the sequencer then waits for the next; the letter that completes a group takes
// a step, then a sum and a reduce for each of the three results. The first letter
// of a message first runs the key setup (cofactor pass over nine entries,
// determinant, inverse lookup) and, in decrypt mode with an invertible key, the
// second pass that scales the adjugate.
// in_if.ready is high only while the sequencer waits for a letter. Results sit
// in an output register; if the receiver stalls, the next result waits in the
// sequencer until that register frees. Reset clears the message state, the key
// and mode registers and output valid; no transaction is pending afterward.
module hill_cipher_3x3_mod26_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [14:0]  cfg_data_i,
  hill3_in_if.sink     in_if,
  hill3_out_if.source  out_if
);

  hill3_pkg::hill3_cmd_t    cmd;
  hill3_pkg::hill3_status_t status;

  hill3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hill3_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_letter_i     (in_if.letter_code),
    .in_end_i        (in_if.message_end),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_letter_o    (out_if.out_letter),
    .out_key_error_o (out_if.key_error),
    .out_run_last_o  (out_if.run_last),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// File: hdl/hill3_checker.sv
`include "assert_macros.svh"

module hill3_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_letter_i,
  input logic       key_error_i,
  input logic       run_last_i
);

  // one letter in flight: ready drops right after a transaction
  `ASSERT_RST(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "input taken twice in a row")

  `ASSERT_RST(a_letter_range, clk_i, rst_ni, out_valid_i |-> (out_letter_i <= 5'd25), "output letter out of range")

  `ASSERT_RST(a_error_shape, clk_i, rst_ni, (out_valid_i && key_error_i) |-> (run_last_i && (out_letter_i == 5'd0)), "malformed key error result")

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_letter_i) && $stable(key_error_i) && $stable(run_last_i)), "stalled output changed")

endmodule

bind hill_cipher_3x3_mod26_core hill3_checker u_hill3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_letter_i (out_if.out_letter),
  .key_error_i  (out_if.key_error),
  .run_last_i   (out_if.run_last)
);

// File: dv/tb_top.sv
module tb_top;

  localparam int SETTLE_CYCLES = 40;    // covers decrypt key setup plus one group
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_LETTERS = 64;

  typedef logic [8:0][4:0] mat_t;

  typedef struct packed {
    logic [4:0] letter;
    logic       key_error;
    logic       run_last;
  } hill_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [14:0] cfg_data_i;

  hill3_in_if  in_ch ();
  hill3_out_if out_ch ();

  hill_cipher_3x3_mod26_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cipher state mirrored from the block
  logic [2:0][14:0] key_rows = '0;
  logic             decrypt_mode = 1'b0;
  logic [1:0][4:0]  group_buf = '0;
  logic [1:0][4:0]  lead_letters = '0;
  int               group_fill = 0;
  int               seen_count = 0;
  mat_t             cipher_mat = '0;
  bit               mat_latched = 1'b0;

  hill_result_t expected_letters[$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  letters_sent = 0;
  int  messages_sent = 0;
  int  key_loads = 0;
  int  error_results = 0;
  int  cycle_count = 0;

  bit  sender_gaps = 1'b1;
  int  burst_left = 0;
  bit  stall_on = 1'b1;
  bit  hold_tok = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  logic [7:0] stall_pat = 8'hb5;
  int  pat_age = 0;

  function automatic int det26(input mat_t m);
    int d, a, b, cof;
    d = 0;
    for (int j = 0; j < 3; j++) begin
      a   = int'(m[3 + (j + 1) % 3]) * int'(m[6 + (j + 2) % 3]);
      b   = int'(m[3 + (j + 2) % 3]) * int'(m[6 + (j + 1) % 3]);
      cof = (a + 676 - b) % 26;
      d   = (d + int'(m[j]) * cof) % 26;
    end
    return d;
  endfunction

  function automatic int inverse26(input int d);
    for (int x = 1; x < 26; x++) begin
      if ((d * x) % 26 == 1) return x;
    end
    return 0;
  endfunction

  function automatic mat_t rows_to_mat(input logic [2:0][14:0] rows);
    mat_t k;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k[3 * i + j] = 5'(int'(rows[i][5 * j +: 5]) % 26);
      end
    end
    return k;
  endfunction

  function automatic logic [14:0] pack_row(input int c0, input int c1, input int c2);
    return {5'(c2), 5'(c1), 5'(c0)};
  endfunction

  function automatic logic [4:0] rand_code();
    if ($urandom_range(0, 5) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // advance the mirrored cipher by one accepted letter, queue what it yields
  task automatic hill_predict_letter(input logic [4:0] code_in, input logic last);
    int   code, r, dinv, a, b, cof, s;
    int   v[3];
    bit   good;
    mat_t k;
    code = int'(code_in) % 26;
    if (!mat_latched) begin
      k = rows_to_mat(key_rows);
      dinv = inverse26(det26(k));
      if (!decrypt_mode || dinv == 0) begin
        cipher_mat = k;
      end else begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            a   = int'(k[3 * ((i + 1) % 3) + (j + 1) % 3]) * int'(k[3 * ((i + 2) % 3) + (j + 2) % 3]);
            b   = int'(k[3 * ((i + 1) % 3) + (j + 2) % 3]) * int'(k[3 * ((i + 2) % 3) + (j + 1) % 3]);
            cof = (a + 676 - b) % 26;
            cipher_mat[3 * j + i] = 5'((cof * dinv) % 26);
          end
        end
      end
      mat_latched = 1'b1;
    end
    good = inverse26(det26(cipher_mat)) != 0;

    if (seen_count < 2) lead_letters[seen_count] = 5'(code);
    if (seen_count < 3) seen_count++;

    r = group_fill + 1;
    v[0] = (r == 1) ? code : int'(group_buf[0]);
    v[1] = (r == 2) ? code : int'(group_buf[1]);
    v[2] = code;

    if (r < 3 && !last) begin
      group_buf[r - 1] = 5'(code);
      group_fill = r;
    end else begin
      // short final group: wrap to the message head
      for (int p = r; p < 3; p++) begin
        v[p] = (seen_count >= 3) ? int'(lead_letters[p - r]) : v[p % r];
      end
      if (good) begin
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int i = 0; i < 3; i++) s += v[i] * int'(cipher_mat[3 * i + j]);
          expected_letters.push_back('{5'(s % 26), 1'b0, last && j == 2});
        end
      end
      group_fill = 0;
    end

    if (last) begin
      if (!good) expected_letters.push_back('{5'd0, 1'b1, 1'b1});
      group_fill  = 0;
      seen_count  = 0;
      mat_latched = 1'b0;
      messages_sent++;
    end
  endtask

  // leaves valid high on return; the next call drives the next letter or lowers it for a gap, settle_block lowers it
  task automatic send_letter(input logic [4:0] code, input logic last);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.letter_code <= code;
    in_ch.message_end <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    letters_sent++;
    hill_predict_letter(code, last);
  endtask

  task automatic send_random_message(input int len);
    for (int n = 0; n < len; n++) send_letter(rand_code(), n == len - 1);
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write enable stays high across the four writes
  task automatic program_key(input logic [14:0] r0, input logic [14:0] r1,
                             input logic [14:0] r2, input logic mode);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hill3_pkg::REG_KEY_ROW0;
    cfg_data_i <= r0;
    @(posedge clk_i);
    cfg_idx_i  <= hill3_pkg::REG_KEY_ROW1;
    cfg_data_i <= r1;
    @(posedge clk_i);
    cfg_idx_i  <= hill3_pkg::REG_KEY_ROW2;
    cfg_data_i <= r2;
    @(posedge clk_i);
    cfg_idx_i  <= hill3_pkg::REG_MODE;
    cfg_data_i <= 15'(mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_rows     = {r2, r1, r0};
    decrypt_mode = mode;
    key_loads++;
  endtask

  task automatic test_reset_key();
    // all-zero key after reset is singular
    send_letter(5'd17, 1'b1);
  endtask

  task automatic test_encrypt_groups();
    program_key(pack_row(6, 24, 1), pack_row(13, 16, 10), pack_row(20, 17, 15), 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd13, 1'b1);
    send_letter(5'd7, 1'b1);
    send_letter(5'd31, 1'b0);
    send_letter(5'd4, 1'b1);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b1);
  endtask

  task automatic test_decrypt();
    // entries above 25 reduce to an invertible key
    program_key(pack_row(29, 2, 0), pack_row(0, 31, 0), pack_row(1, 0, 27), 1'b1);
    send_letter(5'd19, 1'b0);
    send_letter(5'd8, 1'b0);
    send_letter(5'd12, 1'b0);
    send_letter(5'd30, 1'b0);
    send_letter(5'd2, 1'b1);
  endtask

  task automatic test_singular_key();
    program_key(15'h7fff, 15'h7fff, 15'h7fff, 1'b1);
    send_letter(5'd3, 1'b0);
    send_letter(5'd31, 1'b1);
    program_key(pack_row(2, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 1), 1'b0);
    send_letter(5'd5, 1'b0);
    send_letter(5'd6, 1'b0);
    send_letter(5'd7, 1'b0);
    send_letter(5'd8, 1'b1);
  endtask

  task automatic test_receiver_holdoff();
    program_key(pack_row(1, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 1), 1'b0);
    sender_gaps = 1'b0;
    stall_on    = 1'b0;
    hold_tok   <= ~hold_tok;
    send_random_message(12);
    sender_gaps = 1'b1;
    stall_on    = 1'b1;
  endtask

  task automatic test_sender_pause();
    program_key(pack_row(3, 10, 20), pack_row(20, 9, 17), pack_row(9, 4, 17), 1'b1);
    for (int n = 0; n < 4; n++) send_letter(rand_code(), 1'b0);
    // hold the sender mid-message until the block has drained
    in_ch.valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
    send_letter(rand_code(), 1'b0);
    send_letter(rand_code(), 1'b1);
  endtask

  task automatic test_random_messages();
    logic [2:0][14:0] rows;
    int budget, len, sent;
    sent = 0;
    while (sent < RANDOM_LETTERS) begin
      case ($urandom_range(0, 7))
        0: rows = '0;
        1: rows = {3{15'h7fff}};
        2: rows = {15'($urandom()), 15'($urandom()), 15'($urandom())};
        default: begin
          rows = {15'($urandom()), 15'($urandom()), 15'($urandom())};
          while (inverse26(det26(rows_to_mat(rows))) == 0) begin
            rows = {15'($urandom()), 15'($urandom()), 15'($urandom())};
          end
        end
      endcase
      program_key(rows[0], rows[1], rows[2], 1'($urandom_range(0, 1)));
      sender_gaps = $urandom_range(0, 2) != 0;
      stall_on    = $urandom_range(0, 2) != 0;
      budget = 0;
      while (budget < 14) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 9);
        send_random_message(len);
        budget += len;
      end
      sent += budget;
    end
  endtask

  // receiver: rotating stall pattern, reseeded now and then, plus a long hold on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_tok != hold_seen) begin
        hold_seen <= hold_tok;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= stall_on ? stall_pat[0] : 1'b1;
      end
      if (pat_age == 23) begin
        stall_pat <= 8'($urandom()) | 8'h01;
        pat_age <= 0;
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
        pat_age <= pat_age + 1;
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    hill_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_letters.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: letter %0d key_error %0b run_last %0b",
                   out_ch.out_letter, out_ch.key_error, out_ch.run_last);
      end else begin
        want = expected_letters.pop_front();
        if (want.key_error) error_results++;
        if (out_ch.out_letter !== want.letter || out_ch.key_error !== want.key_error ||
            out_ch.run_last !== want.run_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected letter %0d err %0b last %0b, got %0d %0b %0b",
                     results_checked, want.letter, want.key_error, want.run_last,
                     out_ch.out_letter, out_ch.key_error, out_ch.run_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_letters.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= hill3_pkg::REG_KEY_ROW0;
    cfg_data_i        <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.letter_code <= '0;
    in_ch.message_end <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_encrypt_groups();
    test_decrypt();
    test_singular_key();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_messages();
    settle_block();

    $display("covered %0d letters in %0d messages over %0d key settings",
             letters_sent, messages_sent, key_loads);
    $display("checked %0d output transactions, %0d of them key errors, %0d mismatches",
             results_checked, error_results, mismatch_count);
    if (mismatch_count == 0 && expected_letters.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
